FILE: rtl/djs_pkg.sv
// Shared types, codes and helpers for the distance joint step block.
// No dependencies; imported by the top module distance_joint_step.
`timescale 1ns / 1ps
package djs_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_DECIDE,
        ST_DIRX,
        ST_DIRY,
        ST_SCALE,
        ST_MULX,
        ST_MULY,
        ST_FIN
    } t_state;

    typedef logic [1:0] t_action;

    localparam t_action ACT_NONE   = 2'd0;
    localparam t_action ACT_BROKEN = 2'd1;
    localparam t_action ACT_MOVE   = 2'd2;
    localparam t_action ACT_FORCE  = 2'd3;

    localparam logic CFG_REST = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    localparam int MODE_BREAKABLE = 0;
    localparam int MODE_RIGID     = 1;
    localparam int MODE_RUBBER    = 2;
    localparam int MODE_STRONG    = 3;

    // divide by five as (s * RECIP5) >> RECIP5_SHIFT, exact for s below 2^34
    localparam logic [32:0] RECIP5       = 33'd6871947674;
    localparam int          RECIP5_SHIFT = 35;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] res;
        if (v > 41'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -41'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/djs_mul.sv
// Shift-add multiplier, one partial product per cycle over 33 multiplier bits.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module djs_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_a,
    input  logic [32:0] i_b,
    output logic        o_done,
    output logic [68:0] o_prod
);
    logic [68:0] r_a;
    logic [32:0] r_b;
    logic [68:0] r_acc;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= 69'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[67:0], 1'b0};
            r_b <= {1'b0, r_b[32:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: rtl/djs_div.sv
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module djs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    input  logic [6:0]  i_steps,
    output logic        o_done,
    output logic [35:0] o_quo
);
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [35:0] r_quo;
    logic [6:0]  r_left;
    logic        r_busy;
    logic        r_done;
    logic [33:0] rem2;
    logic        ge;

    assign rem2 = {r_rem, r_num[63]};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= i_steps;
            end else if (r_busy) begin
                r_left <= r_left - 7'd1;
                if (r_left == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[34:0], ge};
            r_rem <= ge ? 33'(rem2 - {1'b0, r_den}) : rem2[32:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: rtl/djs_isqrt.sv
// Digit-by-digit floor square root of a 66-bit radicand, one root bit a cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module djs_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_rad,
    output logic        o_done,
    output logic [32:0] o_root
);
    logic [65:0] r_rad;
    logic [36:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [36:0] rem2;
    logic [36:0] trial;
    logic        ge;

    assign rem2  = {r_rem[34:0], r_rad[65:64]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[63:0], 2'b00};
            r_rem  <= ge ? rem2 - trial : rem2;
            r_root <= {r_root[31:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: rtl/distance_joint_step.sv
// Distance joint step: separation, root, direction and spring/rigid response.
// Steps for an accepted input beat: square both separations, add them, take the root and decide
// on the length, which alone settles an idle or broken result; a correction or force then divides
// each separation by the length for the direction (both divides skipped when the points coincide),
// scales the magnitude by the rubberband factor when needed and multiplies it by each component.
// A new input is taken only in the idle state; reset clears control and broken latch.
`timescale 1ns / 1ps
module distance_joint_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side, tdata: point_a_x, point_a_y, point_b_x, point_b_y
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,
    // tuser: a_pinned, b_pinned
    input  logic [1:0]   i_s_axis_tuser,
    // master side, tdata: vec_a_x, vec_a_y, vec_b_x, vec_b_y
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,
    // tuser: action[1:0], apply_a, apply_b
    output logic [3:0]   o_m_axis_tuser,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_data
);
    import djs_pkg::*;

    localparam int TOL_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int TOL     = (TOL_RAW < 1) ? 1 : TOL_RAW;
    localparam int DIR_STEPS = 33 + FRAC_BITS;

    // configuration and persistent state
    logic [30:0] r_rest;
    logic [3:0]  r_mode;
    logic        r_broken;

    // per-item working registers
    t_state             r_state, n_state;
    logic               r_launch;
    logic signed [31:0] r_ax, r_ay, r_bx, r_by;
    logic               r_pa, r_pb;
    logic signed [32:0] r_dx, r_dy;
    logic [65:0]        r_sq;
    logic [32:0]        r_len;
    logic [35:0]        r_m;
    logic [32:0]        r_ux, r_uy;
    logic [39:0]        r_px, r_py;
    t_action            r_act;
    logic               r_early;
    logic               r_compress;

    // output register
    logic         r_ovalid;
    logic [127:0] r_odata;
    logic [3:0]   r_ouser;

    // shared unit hookups
    logic        mul_start, div_start, sqrt_start;
    logic        mul_done, div_done, sqrt_done;
    logic [35:0] mul_a;
    logic [32:0] mul_b;
    logic [68:0] mul_prod;
    logic [63:0] div_num;
    logic [32:0] div_den;
    logic [6:0]  div_steps;
    logic [35:0] div_quo;
    logic [32:0] sqrt_root;

    logic        s_acc, slot_free;
    logic [32:0] mx, my;

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_ovalid || i_m_axis_tready;
    assign mx        = r_dx[32] ? 33'(-r_dx) : r_dx;
    assign my        = r_dy[32] ? 33'(-r_dy) : r_dy;

    // ---------------- decision on the measured length ----------------
    logic signed [34:0] diff;
    logic [33:0]        adiff;
    logic [33:0]        s2;
    logic [35:0]        s_strong;
    logic [33:0]        s_fifth;
    logic               within_tol, do_break, rubber_push;
    logic               rigid, rubber, mode_strong;

    assign rigid       = r_mode[MODE_RIGID];
    assign rubber      = r_mode[MODE_RUBBER];
    assign mode_strong = r_mode[MODE_STRONG];

    assign diff        = $signed({4'b0, r_rest}) - $signed({2'b0, r_len});
    assign adiff       = diff[34] ? 34'(-diff) : diff[33:0];
    assign within_tol  = adiff < 34'(TOL);
    assign do_break    = r_mode[MODE_BREAKABLE] && (adiff > {1'b0, r_rest, 2'b00});
    // compressed rubberband pushes nothing
    assign rubber_push = !rigid && rubber && !diff[34];
    assign s2          = {adiff[32:0], 1'b0};
    assign s_strong    = 36'(s2) + {1'b0, s2, 1'b0};
    // rubberband force: twice the error over five, taken from the reciprocal product
    assign s_fifth     = mul_prod[RECIP5_SHIFT +: 34];

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) n_state = ST_SQX;
            end
            ST_SQX: begin
                if (mul_done) n_state = ST_SQY;
            end
            ST_SQY: begin
                if (mul_done) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_done) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_broken || within_tol || do_break || rubber_push) begin
                    n_state = ST_FIN;
                end else if (r_len != '0) begin
                    n_state = ST_DIRX;
                end else if (!rigid && rubber) begin
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_MULX;
                end
            end
            ST_DIRX: begin
                if (div_done) n_state = ST_DIRY;
            end
            ST_DIRY: begin
                if (div_done) n_state = (!rigid && rubber) ? ST_SCALE : ST_MULX;
            end
            ST_SCALE: begin
                if (mul_done) n_state = ST_MULX;
            end
            ST_MULX: begin
                if (mul_done) n_state = ST_MULY;
            end
            ST_MULY: begin
                if (mul_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: unit launches and operands ----------------
    always_comb begin
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = 36'(mx);
        mul_b      = mx;
        div_num    = {mx, 31'b0};
        div_den    = r_len;
        div_steps  = 7'(DIR_STEPS);
        case (r_state)
            ST_SQX: begin
                mul_start = !r_launch;
            end
            ST_SQY: begin
                mul_start = !r_launch;
                mul_a     = 36'(my);
                mul_b     = my;
            end
            ST_SQRT: begin
                sqrt_start = !r_launch;
            end
            ST_DIRX: begin
                div_start = !r_launch;
            end
            ST_DIRY: begin
                div_start = !r_launch;
                div_num   = {my, 31'b0};
            end
            ST_SCALE: begin
                mul_start = !r_launch;
                mul_a     = r_m;
                mul_b     = RECIP5;
            end
            ST_MULX: begin
                mul_start = !r_launch;
                mul_a     = r_m;
                mul_b     = r_ux;
            end
            ST_MULY: begin
                mul_start = !r_launch;
                mul_a     = r_m;
                mul_b     = r_uy;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;

    // ---------------- result assembly ----------------
    logic signed [40:0] pxs, pys, uax, uay;
    logic signed [40:0] axe, aye, bxe, bye;
    logic signed [32:0] sumx, sumy;
    logic signed [40:0] cx, cy;
    logic signed [40:0] va_x, va_y, vb_x, vb_y;
    logic               ea, eb;
    t_action            act;

    assign pxs  = $signed({1'b0, r_px});
    assign pys  = $signed({1'b0, r_py});
    assign uax  = r_dx[32] ? -pxs : pxs;
    assign uay  = r_dy[32] ? -pys : pys;
    assign axe  = 41'(r_ax);
    assign aye  = 41'(r_ay);
    assign bxe  = 41'(r_bx);
    assign bye  = 41'(r_by);
    assign sumx = 33'(r_ax) + 33'(r_bx);
    assign sumy = 33'(r_ay) + 33'(r_by);
    // midpoint, halved toward zero
    assign cx   = 41'((sumx + $signed({32'b0, sumx[32]})) >>> 1);
    assign cy   = 41'((sumy + $signed({32'b0, sumy[32]})) >>> 1);

    always_comb begin
        va_x = '0;
        va_y = '0;
        vb_x = '0;
        vb_y = '0;
        ea   = 1'b0;
        eb   = 1'b0;
        act  = r_act;
        if (!r_early) begin
            if (rigid) begin
                act = ACT_MOVE;
                if (r_pa) begin
                    eb   = 1'b1;
                    vb_x = axe + uax;
                    vb_y = aye + uay;
                end else if (r_pb) begin
                    ea   = 1'b1;
                    va_x = bxe - uax;
                    va_y = bye - uay;
                end else begin
                    ea   = 1'b1;
                    eb   = 1'b1;
                    va_x = cx - uax;
                    va_y = cy - uay;
                    vb_x = cx + uax;
                    vb_y = cy + uay;
                end
            end else begin
                act = ACT_FORCE;
                ea  = 1'b1;
                eb  = 1'b1;
                if (!r_compress) begin
                    // stretched: pull the ends together
                    va_x = uax;
                    va_y = uay;
                    vb_x = -uax;
                    vb_y = -uay;
                end else begin
                    va_x = -uax;
                    va_y = -uay;
                    vb_x = uax;
                    vb_y = uay;
                end
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_broken <= 1'b0;
            r_rest   <= '0;
            r_mode   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            // hold the launch flag until the state moves on
            r_launch <= (r_state == n_state) ? (r_launch | mul_start | div_start | sqrt_start)
                                             : 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REST: r_rest <= i_cfg_data;
                    CFG_MODE: r_mode <= i_cfg_data[3:0];
                    default:  r_mode <= r_mode;
                endcase
            end
            if (r_state == ST_DECIDE && !r_broken && !within_tol && do_break) begin
                r_broken <= 1'b1;
            end
            if (r_state == ST_FIN && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    r_ax <= $signed(i_s_axis_tdata[31:0]);
                    r_ay <= $signed(i_s_axis_tdata[63:32]);
                    r_bx <= $signed(i_s_axis_tdata[95:64]);
                    r_by <= $signed(i_s_axis_tdata[127:96]);
                    r_pa <= i_s_axis_tuser[0];
                    r_pb <= i_s_axis_tuser[1];
                    r_dx <= 33'($signed(i_s_axis_tdata[95:64]))
                          - 33'($signed(i_s_axis_tdata[31:0]));
                    r_dy <= 33'($signed(i_s_axis_tdata[127:96]))
                          - 33'($signed(i_s_axis_tdata[63:32]));
                end
            end
            ST_SQX: begin
                if (mul_done) r_sq <= mul_prod[65:0];
            end
            ST_SQY: begin
                if (mul_done) r_sq <= r_sq + mul_prod[65:0];
            end
            ST_SQRT: begin
                if (sqrt_done) r_len <= sqrt_root;
            end
            ST_DECIDE: begin
                r_ux       <= '0;
                r_uy       <= '0;
                r_compress <= !diff[34];
                r_early    <= 1'b1;
                // a length within tolerance answers nothing, even on a breakable joint
                if (r_broken || (!within_tol && do_break)) begin
                    r_act <= ACT_BROKEN;
                end else if (within_tol || rubber_push) begin
                    r_act <= ACT_NONE;
                end else begin
                    r_act   <= ACT_NONE;
                    r_early <= 1'b0;
                end
                if (rigid) begin
                    r_m <= (r_pa || r_pb) ? 36'(r_rest) : 36'(r_rest[30:1]);
                end else if (rubber) begin
                    r_m <= 36'(s2);
                end else begin
                    r_m <= mode_strong ? s_strong : 36'(s2);
                end
            end
            ST_DIRX: begin
                if (div_done) r_ux <= div_quo[32:0];
            end
            ST_DIRY: begin
                if (div_done) r_uy <= div_quo[32:0];
            end
            ST_SCALE: begin
                if (mul_done) begin
                    r_m <= mode_strong ? 36'(s_fifth) + {1'b0, s_fifth, 1'b0}
                                       : 36'(s_fifth);
                end
            end
            ST_MULX: begin
                if (mul_done) r_px <= mul_prod[FRAC_BITS +: 40];
            end
            ST_MULY: begin
                if (mul_done) r_py <= mul_prod[FRAC_BITS +: 40];
            end
            ST_FIN: begin
                if (slot_free) begin
                    r_odata <= {sat32(vb_y), sat32(vb_x), sat32(va_y), sat32(va_x)};
                    r_ouser <= {eb, ea, act};
                end
            end
            default: begin
                r_m <= r_m;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    // ---------------- shared units ----------------
    djs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    djs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    djs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

`ifndef SYNTHESIS
    // once broken, the joint stays broken until reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_broken |=> r_broken)
        else $error("broken latch cleared");

    // idle and broken results carry no vectors
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ACT_NONE ||
                            o_m_axis_tuser[1:0] == ACT_BROKEN)
        |-> o_m_axis_tuser[3:2] == 2'b00)
        else $error("vector applied on a no-op result");

    // a position correction always moves at least one end
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == ACT_MOVE |-> o_m_axis_tuser[3:2] != 2'b00)
        else $error("correction without a moved end");

    // the multiplier only finishes while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_SQX || r_state == ST_SQY || r_state == ST_SCALE ||
                      r_state == ST_MULX || r_state == ST_MULY))
        else $error("stray multiplier completion");
`endif
endmodule
